>>> rtl/b2b_pkg.sv
package b2b_pkg;

	localparam logic [63:0] IV [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
		64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam logic [31:0] PARAM_BASE = 32'h01010000;
	localparam int ROUNDS = 12;
	localparam int GSTEPS = 8;

	// message schedule, ten rows of sixteen word indexes
	localparam logic [3:0] SIGMA [10][16] = '{
		'{ 0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
		'{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
		'{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
		'{ 7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
		'{ 9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
		'{ 2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
		'{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
		'{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
		'{ 6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
		'{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}
	};

	// work vector indexes a, b, c, d for each of the eight g steps
	localparam logic [3:0] GIDX [8][4] = '{
		'{0, 4, 8, 12}, '{1, 5, 9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15},
		'{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7, 8, 13}, '{3, 4, 9, 14}
	};

	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		logic [63:0] d;
	} quad_t;

	function automatic logic [63:0] rotr(input logic [63:0] v, input int n);
		rotr = (v >> n) | (v << (64 - n));
	endfunction

endpackage

>>> rtl/b2b_gunit.sv
// one full g function on four work words and two message words
module b2b_gunit import b2b_pkg::*; (
	input  quad_t       qin,
	input  logic [63:0] x,
	input  logic [63:0] y,
	output quad_t       qout
);
	logic [63:0] a1, d1, c1, b1, a2, d2, c2, b2;

	// two half rounds of add, xor and rotate
	always_comb begin
		a1 = qin.a + qin.b + x;
		d1 = rotr(qin.d ^ a1, 32);
		c1 = qin.c + d1;
		b1 = rotr(qin.b ^ c1, 24);
		a2 = a1 + b1 + y;
		d2 = rotr(d1 ^ a2, 16);
		c2 = c1 + d2;
		b2 = rotr(b1 ^ c2, 63);
		qout = '{a: a2, b: b2, c: c2, d: d2};
	end
endmodule

>>> rtl/blake2b_hash_core.sv
// channel  | direction | request payload
// s_axis   | in        | tdata = message_word[63:0], tuser = valid_bytes[3:0], last_word
// m_axis   | out       | tdata = digest_word[63:0], tuser = digest_valid_bytes[3:0], last
// cfg      | in        | data = digest size in bytes[6:0]
// a word is accepted first, then appended into the block buffer
// a byte that meets a full block first runs a compression: a setup step,
// g steps (12 rounds of 8 on one shared unit) and one fold
// a last word adds a final compression and then up to 8 digest words
// arst_n clears control state and loads the chain for a 64 byte digest
// s_axis_tready is high only in idle; a low m_axis_tready holds the digest words
module blake2b_hash_core import b2b_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // message_word
	input  logic [4:0]  s_axis_tuser,  // valid_bytes[3:0], last_word[4]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // digest_word
	output logic [4:0]  m_axis_tuser,  // digest_valid_bytes[3:0], digest_last[4]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);
	typedef enum logic [2:0] {IDLE, INIT, ROUND, FOLD, EMIT} state_t;

	state_t      state_q;
	logic [63:0] h_q [8];
	logic [63:0] v_q [16];
	logic [63:0] m_q [16];
	logic [63:0] cnt_q;
	logic [7:0]  nb_q;
	logic [6:0]  len_q, act_q;
	logic [3:0]  rnd_q;
	logic [2:0]  gs_q, ow_q;
	logic        fin_q, pend_q;
	logic [63:0] pw_q, pend_w_q;
	logic [3:0]  pv_q, pend_v_q;
	logic        pl_q, pend_l_q;

	quad_t       qin, qout;
	logic [3:0]  srow;
	logic [6:0]  cfg_len, rem;
	logic [3:0]  nv;
	logic        s_acc;

	assign s_axis_tready = (state_q == IDLE);
	assign cfg_ready = 1'b1;
	assign s_acc = s_axis_tvalid && s_axis_tready;

	// clamped length from the write data, clamped input byte count, digest bytes left
	always_comb begin
		cfg_len = cfg_data;
		if (cfg_data == 7'd0) cfg_len = 7'd1;
		if (cfg_data > 7'd64) cfg_len = 7'd64;
		nv = (s_axis_tuser[3:0] > 4'd8) ? 4'd8 : s_axis_tuser[3:0];
		rem = act_q - {1'b0, ow_q, 3'd0};
	end

	// operand selection for the shared g unit
	always_comb begin
		srow = (rnd_q >= 4'd10) ? rnd_q - 4'd10 : rnd_q;
		qin = '{a: v_q[GIDX[gs_q][0]], b: v_q[GIDX[gs_q][1]],
			c: v_q[GIDX[gs_q][2]], d: v_q[GIDX[gs_q][3]]};
	end

	b2b_gunit u_g (
		.qin (qin),
		.x   (m_q[SIGMA[srow][{gs_q, 1'b0}]]),
		.y   (m_q[SIGMA[srow][{gs_q, 1'b1}]]),
		.qout(qout)
	);

	assign m_axis_tvalid = (state_q == EMIT);
	assign m_axis_tdata = h_q[ow_q];
	assign m_axis_tuser = {(rem <= 7'd8), (rem > 7'd8) ? 4'd8 : rem[3:0]};

	// byte append of the pending word into the buffer, stops at a full block
	function automatic void put_bytes(ref logic [63:0] m [16], ref logic [7:0] nb,
		ref logic [63:0] cnt, input logic [63:0] w, input logic [3:0] n);
		logic [6:0] p;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < n && nb < 8'd128) begin
				p = nb[6:0];
				m[p[6:3]][p[2:0]*8 +: 8] = w[i*8 +: 8];
				nb = nb + 8'd1;
				cnt = cnt + 64'd1;
			end
		end
	endfunction

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			len_q <= 7'd64;
			act_q <= 7'd64;
			cnt_q <= '0;
			nb_q <= '0;
			pend_q <= 1'b0;
			rnd_q <= '0;
			gs_q <= '0;
			ow_q <= '0;
			fin_q <= 1'b0;
			for (int i = 0; i < 8; i++)
				h_q[i] <= (i == 0) ? IV[0] ^ {32'd0, PARAM_BASE | 32'd64} : IV[i];
		end else begin
			if (cfg_valid) begin
				len_q <= cfg_len;
				if (state_q == IDLE && cnt_q == '0 && nb_q == '0 && !pend_q) begin
					act_q <= cfg_len;
					h_q[0] <= IV[0] ^ {32'd0, PARAM_BASE | {25'd0, cfg_len}};
				end
			end
			case (state_q)
				IDLE: begin
					if (s_acc) begin
						pw_q <= s_axis_tdata;
						pv_q <= nv;
						pl_q <= s_axis_tuser[4];
						state_q <= INIT;
					end
				end
				INIT: begin
					// compress a held full block when more bytes arrive
					if (nb_q == 8'd128 && pv_q != 4'd0) begin
						fin_q <= 1'b0;
						nb_q <= '0;
						pend_q <= 1'b1;
						pend_w_q <= pw_q;
						pend_v_q <= pv_q;
						pend_l_q <= pl_q;
						for (int i = 0; i < 8; i++) begin
							v_q[i] <= h_q[i];
							v_q[8+i] <= IV[i];
						end
						v_q[12] <= IV[4] ^ cnt_q;
						rnd_q <= '0;
						gs_q <= '0;
						state_q <= ROUND;
					end else begin
						logic [63:0] mt [16];
						logic [7:0] nbt;
						logic [63:0] ct;
						logic [3:0] take, left;
						mt = m_q;
						nbt = nb_q;
						ct = cnt_q;
						put_bytes(mt, nbt, ct, pw_q, pv_q);
						take = 4'(nbt - nb_q);
						left = pv_q - take;
						if (pl_q && left == 4'd0) begin
							for (int p = 0; p < 128; p++)
								if (8'(p) >= nbt) mt[p/8][(p%8)*8 +: 8] = 8'd0;
						end
						m_q <= mt;
						nb_q <= nbt;
						cnt_q <= ct;
						pend_q <= 1'b0;
						if (left != 4'd0) begin
							// block filled mid word, the rest follows the compression
							pw_q <= pw_q >> {take, 3'b000};
							pv_q <= left;
						end else if (pl_q) begin
							fin_q <= 1'b1;
							for (int i = 0; i < 8; i++) begin
								v_q[i] <= h_q[i];
								v_q[8+i] <= IV[i];
							end
							v_q[12] <= IV[4] ^ ct;
							v_q[14] <= ~IV[6];
							rnd_q <= '0;
							gs_q <= '0;
							state_q <= ROUND;
						end else begin
							state_q <= IDLE;
						end
					end
				end
				ROUND: begin
					v_q[GIDX[gs_q][0]] <= qout.a;
					v_q[GIDX[gs_q][1]] <= qout.b;
					v_q[GIDX[gs_q][2]] <= qout.c;
					v_q[GIDX[gs_q][3]] <= qout.d;
					gs_q <= gs_q + 3'd1;
					if (gs_q == 3'(GSTEPS - 1)) begin
						rnd_q <= rnd_q + 4'd1;
						if (rnd_q == 4'(ROUNDS - 1)) state_q <= FOLD;
					end
				end
				FOLD: begin
					for (int i = 0; i < 8; i++)
						h_q[i] <= h_q[i] ^ v_q[i] ^ v_q[8+i];
					ow_q <= '0;
					if (fin_q) begin
						state_q <= EMIT;
					end else begin
						pw_q <= pend_w_q;
						pv_q <= pend_v_q;
						pl_q <= pend_l_q;
						state_q <= INIT;
					end
				end
				EMIT: begin
					if (m_axis_tready) begin
						ow_q <= ow_q + 3'd1;
						if (rem <= 7'd8) begin
							// restart for the next message
							for (int i = 0; i < 8; i++)
								h_q[i] <= (i == 0) ?
									IV[0] ^ {32'd0, PARAM_BASE | {25'd0, len_q}} : IV[i];
							act_q <= len_q;
							cnt_q <= '0;
							nb_q <= '0;
							fin_q <= 1'b0;
							state_q <= IDLE;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// a digest word only appears after a final compression
	a_emit_fin: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> fin_q) else $error("digest without final block");
	// the buffer never holds more than one block
	a_nb: assert property (@(posedge clk) disable iff (!arst_n)
		nb_q <= 8'd128) else $error("buffer overfull");
	// no input taken while a compression runs
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ROUND) |-> !s_axis_tready) else $error("ready while busy");
endmodule

>>> dv/tb_blake2b_hash_core.sv
`timescale 1ns / 1ps

module tb_blake2b_hash_core;
	import b2b_pkg::*;

	typedef logic [63:0] vec16_t [16];

	typedef struct {
		logic [63:0] word;
		logic [3:0]  nbytes;
		logic        last;
	} digest_t;

	typedef struct {
		logic [63:0] word;
		logic [3:0]  nbytes;
		logic        last;
	} msg_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [4:0]  s_axis_tuser = '0;  // valid_bytes[3:0], last_word[4]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic [4:0]  m_axis_tuser;       // digest_valid_bytes[3:0], digest_last[4]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data = '0;

	blake2b_hash_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hash state of the predictor
	logic [63:0] chain [8];
	logic [63:0] msg_count;
	logic [63:0] blk [16];
	int unsigned blk_fill;
	int unsigned len_reg;
	int unsigned len_msg;

	digest_t     digest_q [$];
	int          errors = 0;
	int          items_sent = 0;
	bit          hold_req = 1'b0;
	int          burst_left = 0;

	function automatic logic [63:0] ror64(logic [63:0] v, int n);
		return (v >> n) | (v << (64 - n));
	endfunction

	function automatic vec16_t mix(vec16_t v, int a, int b, int c, int d,
			logic [63:0] x, logic [63:0] y);
		v[a] = v[a] + v[b] + x;
		v[d] = ror64(v[d] ^ v[a], 32);
		v[c] = v[c] + v[d];
		v[b] = ror64(v[b] ^ v[c], 24);
		v[a] = v[a] + v[b] + y;
		v[d] = ror64(v[d] ^ v[a], 16);
		v[c] = v[c] + v[d];
		v[b] = ror64(v[b] ^ v[c], 63);
		return v;
	endfunction

	task automatic compress(input bit fin);
		vec16_t v;
		int     row;
		for (int i = 0; i < 8; i++) begin
			v[i] = chain[i];
			v[8 + i] = IV[i];
		end
		v[12] ^= msg_count;
		if (fin)
			v[14] = ~v[14];
		for (int r = 0; r < ROUNDS; r++) begin
			row = r % 10;
			for (int g = 0; g < GSTEPS; g++)
				v = mix(v, GIDX[g][0], GIDX[g][1], GIDX[g][2], GIDX[g][3],
					blk[SIGMA[row][2 * g]], blk[SIGMA[row][2 * g + 1]]);
		end
		for (int i = 0; i < 8; i++)
			chain[i] ^= v[i] ^ v[8 + i];
	endtask

	task automatic begin_msg();
		for (int i = 0; i < 8; i++)
			chain[i] = IV[i];
		len_msg = len_reg;
		chain[0] ^= {32'd0, PARAM_BASE} | 64'(len_msg);
		msg_count = '0;
		blk_fill = 0;
	endtask

	task automatic absorb_byte(input logic [7:0] b);
		if (blk_fill >= 128) begin
			compress(1'b0);
			blk_fill = 0;
		end
		blk[blk_fill / 8][(blk_fill % 8) * 8 +: 8] = b;
		blk_fill++;
		msg_count++;
	endtask

	// accepted word: absorb, and on the last word queue the digest
	task automatic predict_word(input logic [63:0] w, input logic [4:0] u);
		int unsigned n;
		int unsigned nw;
		int unsigned rem;
		digest_t     d;
		n = (u[3:0] > 8) ? 8 : u[3:0];
		for (int i = 0; i < n; i++)
			absorb_byte(w[8 * i +: 8]);
		if (u[4]) begin
			for (int p = blk_fill; p < 128; p++)
				blk[p / 8][(p % 8) * 8 +: 8] = 8'h00;
			compress(1'b1);
			nw = (len_msg + 7) / 8;
			for (int i = 0; i < nw; i++) begin
				rem = len_msg - 8 * i;
				d.word = chain[i];
				d.nbytes = (rem > 8) ? 4'd8 : 4'(rem);
				d.last = (i + 1 == nw);
				digest_q.push_back(d);
			end
			begin_msg();
		end
	endtask

	task automatic predict_cfg(input logic [6:0] val);
		int unsigned l;
		l = val;
		if (l == 0)
			l = 1;
		if (l > 64)
			l = 64;
		len_reg = l;
		if (msg_count == 0 && blk_fill == 0)
			begin_msg();
	endtask

	// offer one word with bursty gaps, wait for the request to be taken
	task automatic send_word(input logic [63:0] w, input logic [4:0] u);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= w;
		s_axis_tuser <= u;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_word(w, u);
		items_sent++;
	endtask

	task automatic go_idle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (digest_q.size() != 0)
			@(posedge clk);
		// a trailing full block may still be compressing
		repeat (200) @(posedge clk);
	endtask

	task automatic write_len(input logic [6:0] val);
		go_idle();
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		predict_cfg(val);
	endtask

	// random message: mostly full words, odd tail, some noise in the counts
	task automatic send_message(input int nwords);
		logic [63:0] w;
		logic [3:0]  nb;
		for (int i = 0; i < nwords; i++) begin
			w = {$urandom, $urandom};
			nb = 4'd8;
			if ($urandom_range(0, 19) == 0)
				nb = 4'($urandom_range(0, 15));
			if (i == nwords - 1 && $urandom_range(0, 2) != 0)
				nb = 4'($urandom_range(0, 8));
			send_word(w, {i == nwords - 1, nb});
		end
	endtask

	// receiver: stall pattern per window, long hold-off on request
	int rx_mode = 0;
	int rx_win = 0;
	int rx_hold = 0;
	always @(posedge clk) begin
		digest_t d;
		if (m_axis_tvalid && m_axis_tready) begin
			if (digest_q.size() == 0) begin
				$error("digest word with none expected: %h", m_axis_tdata);
				errors++;
			end else begin
				d = digest_q.pop_front();
				if (m_axis_tdata !== d.word) begin
					$error("digest_word exp %h got %h", d.word, m_axis_tdata);
					errors++;
				end
				if (m_axis_tuser[3:0] !== d.nbytes) begin
					$error("digest_valid_bytes exp %0d got %0d", d.nbytes,
						m_axis_tuser[3:0]);
					errors++;
				end
				if (m_axis_tuser[4] !== d.last) begin
					$error("digest_last exp %0d got %0d", d.last, m_axis_tuser[4]);
					errors++;
				end
			end
		end
		if (hold_req && rx_hold == 0)
			rx_hold = 600;
		if (rx_hold > 0) begin
			rx_hold--;
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_win == 0) begin
				rx_win = $urandom_range(8, 40);
				rx_mode = $urandom_range(0, 2);
			end
			rx_win--;
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 1) == 1);
				default: m_axis_tready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	initial begin
		#20ms;
		$display("blake2b_hash_core regression: fail");
		$finish;
	end

	// directed rows: "abc", empty, short words mid-message, oversize counts
	msg_row_t dir_rows [] = '{
		'{64'h0000000000636261, 4'd3, 1'b1},
		'{64'h0, 4'd0, 1'b1},
		'{64'hffffffffffffffff, 4'd8, 1'b1},
		'{64'h0000000000000000, 4'd8, 1'b1},
		'{64'h1122334455667788, 4'd2, 1'b0},
		'{64'haabbccddeeff0011, 4'd0, 1'b0},
		'{64'h0123456789abcdef, 4'd15, 1'b0},
		'{64'hfedcba9876543210, 4'd9, 1'b1},
		'{64'h8000000000000001, 4'd1, 1'b0},
		'{64'hdeadbeefcafef00d, 4'd0, 1'b1},
		'{64'h5555aaaa5555aaaa, 4'd7, 1'b1}
	};

	initial begin
		len_reg = 64;
		begin_msg();
		for (int i = 0; i < 16; i++)
			blk[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].word, {dir_rows[i].last, dir_rows[i].nbytes});
		// exactly one block, then one block and a byte
		for (int i = 0; i < 16; i++)
			send_word(~64'(i), {i == 15, 4'd8});
		for (int i = 0; i < 17; i++)
			send_word(64'(i) << 56, {i == 16, (i == 16) ? 4'd1 : 4'd8});

		write_len(7'd0);
		send_message(3);
		write_len(7'd127);
		send_message(2);
		write_len(7'd1);
		send_message(1);
		write_len(7'd33);

		// stall the receiver while digests and input pile up
		hold_req = 1'b1;
		repeat (2) @(posedge clk);
		hold_req = 1'b0;
		for (int m = 0; m < 4; m++)
			send_message($urandom_range(1, 20));

		while (items_sent < 460) begin
			if ($urandom_range(0, 5) == 0)
				write_len(7'($urandom_range(0, 127)));
			case ($urandom_range(0, 9))
				0: send_message(16);
				1: send_message(32);
				2: send_message($urandom_range(17, 40));
				default: send_message($urandom_range(1, 8));
			endcase
		end
		write_len(7'd64);
		send_message(5);

		go_idle();
		if (errors == 0 && digest_q.size() == 0)
			$display("blake2b_hash_core regression: pass");
		else
			$display("blake2b_hash_core regression: fail");
		$finish;
	end

endmodule
